FILE: src/nfba_pkg.sv
`default_nettype none
package nfba_pkg;

  // identifier and limit width, fixed by the interface
  localparam int ID_W   = 11;
  localparam int ID_MAX = (1 << ID_W) - 1;
  localparam int ID_RST = 1024;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_TDATA_W = 16;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

endpackage
`default_nettype wire

FILE: src/next_fit_bitmap_id_allocator_unit.sv
// Allocate: a request taken on in_tvalid/in_tready scans the bitmap words in LOOK, one word
//   per cycle through the find-first-free unit, then hands the result to the output register;
//   release runs index split, bit check and clear, result; rejected requests go straight to result.
// Throughput: one transfer at a time; the next request is taken only once the result is registered
//   and no id_limit write is pending (in_tready is low while cfg_tvalid is high).
// Reset (rst_n low, synchronous) and id_limit writes clear the map word by word in the CLR state.
`default_nettype none
module next_fit_bitmap_id_allocator_unit #(
  parameter int MAX_IDS   = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nfba_pkg::IN_TDATA_W-1:0]  in_tdata,   // [10:0] release_id
  input  logic                             in_tuser,   // [0] cmd
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [nfba_pkg::OUT_TDATA_W-1:0] out_tdata,  // [10:0] granted_id
  output logic [nfba_pkg::STATUS_W-1:0]    out_tuser,  // [1:0] status
  // id_limit write channel
  input  logic                             cfg_tvalid,
  output logic                             cfg_tready,
  input  logic [nfba_pkg::CFG_TDATA_W-1:0] cfg_tdata   // [10:0] id_limit
);

  import nfba_pkg::*;

  localparam int NUM_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  // an index is below the limit, which is capped at MAX_IDS and at ID_MAX
  localparam int IW        = ($clog2(MAX_IDS) < ID_W) ? $clog2(MAX_IDS) : ID_W;
  localparam int SW        = ID_W + 1;   // room for index + WORD_BITS sums

  localparam logic [ID_W-1:0] LIM_CAP = ID_W'((MAX_IDS > ID_MAX) ? ID_MAX : MAX_IDS);
  localparam logic [ID_W-1:0] LIM_RST = ID_W'((ID_RST > MAX_IDS) ? MAX_IDS : ID_RST);
  localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1);

  // sequencer states
  //   CLR  : bitmap clearing pass
  //   LOOK : allocate scan, one word per cycle
  //   DIV  : release, split index into word / bit
  //   REL  : release, check and clear the bit
  //   PUT  : hand result to the output register
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_REL,
    S_PUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [ID_W-1:0]    lim_r, lim_nxt;           // saturated id_limit
  logic [ID_W-1:0]    count_r, count_nxt;       // ids in use
  logic [AW-1:0]      cur_word_r, cur_word_nxt; // next-fit cursor as word / bit / word base
  logic [BW-1:0]      cur_bit_r, cur_bit_nxt;
  logic [IW-1:0]      cur_base_r, cur_base_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]      scan_word_r, scan_word_nxt;
  logic [IW-1:0]      scan_base_r, scan_base_nxt;
  logic [BW-1:0]      lo_bit_r, lo_bit_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [BW-1:0]      rel_bit_r, rel_bit_nxt;
  status_t            res_status_r, res_status_nxt;
  logic [ID_W-1:0]    res_id_r, res_id_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rd_data;

  logic [SW-1:0]      span;
  logic               found;
  logic [BW-1:0]      hit_bit;
  logic [IW-1:0]      cur_idx;

  logic               div_start;
  logic [IW-1:0]      div_dividend;
  logic               div_done;
  logic [AW-1:0]      div_quot;
  logic [BW-1:0]      div_rem;

  // read port follows the next scan word, so rd_data holds mem[scan_word_r] (before any write at that edge)
  nfba_bitmap_ram #(
    .WORD_BITS (WORD_BITS),
    .DEPTH     (NUM_WORDS),
    .AW        (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (scan_word_nxt),
    .rd_data (rd_data)
  );

  assign span = SW'(lim_r) - SW'(scan_base_r);

  nfba_ffz #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW),
    .SW        (SW)
  ) u_ffz (
    .used_word (rd_data),
    .lo_bit    (lo_bit_r),
    .span      (span),
    .found     (found),
    .hit_bit   (hit_bit)
  );

  nfba_wdiv #(
    .WORD_BITS (WORD_BITS),
    .IW        (IW),
    .AW        (AW),
    .BW        (BW)
  ) u_wdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem_bits (div_rem)
  );

  assign cur_idx    = cur_base_r + IW'(cur_bit_r);
  assign in_tready  = (state_r == S_IDLE) && !cfg_tvalid;
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_id_r);
  assign out_tuser  = out_status_r;

  always_comb begin
    logic [ID_W-1:0] in_id;
    logic [ID_W-1:0] cfg_lim;
    logic [IW-1:0]   hit_idx;
    logic [SW-1:0]   nxt_base;
    logic [SW-1:0]   nxt_lin;

    state_nxt      = state_r;
    lim_nxt        = lim_r;
    count_nxt      = count_r;
    cur_word_nxt   = cur_word_r;
    cur_bit_nxt    = cur_bit_r;
    cur_base_nxt   = cur_base_r;
    clr_addr_nxt   = clr_addr_r;
    scan_word_nxt  = scan_word_r;
    scan_base_nxt  = scan_base_r;
    lo_bit_nxt     = lo_bit_r;
    idx_nxt        = idx_r;
    rel_bit_nxt    = rel_bit_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;

    mem_we       = 1'b0;
    mem_waddr    = scan_word_r;
    mem_wdata    = rd_data;
    div_start    = 1'b0;

    in_id        = in_tdata[ID_W-1:0];
    cfg_lim      = cfg_tdata[ID_W-1:0];
    div_dividend = IW'(in_id - ID_W'(1));
    hit_idx      = scan_base_r + IW'(hit_bit);
    nxt_base     = SW'(scan_base_r) + SW'(WORD_BITS);
    nxt_lin      = SW'(hit_idx) + SW'(1);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          res_id_nxt = '0;
          if (cmd_t'(in_tuser) == CMD_ALLOC) begin
            if ((lim_r == '0) || (count_r >= lim_r)) begin
              res_status_nxt = ST_EXHAUSTED;
              state_nxt      = S_PUT;
            end else if (SW'(cur_idx) >= SW'(lim_r)) begin
              // cursor past a lowered limit restarts at the bottom
              scan_word_nxt = '0;
              scan_base_nxt = '0;
              lo_bit_nxt    = '0;
              state_nxt     = S_LOOK;
            end else begin
              scan_word_nxt = cur_word_r;
              scan_base_nxt = cur_base_r;
              lo_bit_nxt    = cur_bit_r;
              state_nxt     = S_LOOK;
            end
          end else begin
            if ((in_id == '0) || (in_id > lim_r)) begin
              res_status_nxt = ST_INVALID;
              state_nxt      = S_PUT;
            end else begin
              idx_nxt   = div_dividend;
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
        end
      end

      S_LOOK: begin
        if (found) begin
          mem_we         = 1'b1;
          mem_wdata      = rd_data | (ONE_W << hit_bit);
          count_nxt      = count_r + ID_W'(1);
          res_status_nxt = ST_OK;
          res_id_nxt     = ID_W'(hit_idx) + ID_W'(1);
          if (nxt_lin >= SW'(lim_r)) begin
            cur_word_nxt = '0;
            cur_bit_nxt  = '0;
            cur_base_nxt = '0;
          end else if (hit_bit == BW'(WORD_BITS - 1)) begin
            cur_word_nxt = scan_word_r + AW'(1);
            cur_bit_nxt  = '0;
            cur_base_nxt = IW'(nxt_base);
          end else begin
            cur_word_nxt = scan_word_r;
            cur_bit_nxt  = hit_bit + BW'(1);
            cur_base_nxt = scan_base_r;
          end
          state_nxt = S_PUT;
        end else begin
          // nothing free here: step to the next word, wrapping at the limit
          lo_bit_nxt = '0;
          if (nxt_base >= SW'(lim_r)) begin
            scan_word_nxt = '0;
            scan_base_nxt = '0;
          end else begin
            scan_word_nxt = scan_word_r + AW'(1);
            scan_base_nxt = IW'(nxt_base);
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          scan_word_nxt = div_quot;
          rel_bit_nxt   = div_rem;
          state_nxt     = S_REL;
        end
      end

      S_REL: begin
        res_id_nxt = '0;
        if (!rd_data[rel_bit_r]) begin
          res_status_nxt = ST_NOT_ALLOC;
        end else begin
          res_status_nxt = ST_OK;
          mem_we         = 1'b1;
          mem_wdata      = rd_data & ~(ONE_W << rel_bit_r);
          if (count_r != '0) begin
            count_nxt = count_r - ID_W'(1);
          end
          // pull the cursor back to the freed id when it lies below the cursor
          if (idx_r < cur_idx) begin
            cur_word_nxt = scan_word_r;
            cur_bit_nxt  = rel_bit_r;
            cur_base_nxt = idx_r - IW'(rel_bit_r);
          end
        end
        state_nxt = S_PUT;
      end

      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLR;
      end
    endcase

    // id_limit write restarts the map
    if (cfg_tvalid && cfg_tready) begin
      lim_nxt      = (cfg_lim > LIM_CAP) ? LIM_CAP : cfg_lim;
      count_nxt    = '0;
      cur_word_nxt = '0;
      cur_bit_nxt  = '0;
      cur_base_nxt = '0;
      clr_addr_nxt = '0;
      state_nxt    = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      lim_r       <= LIM_RST;
      count_r     <= '0;
      cur_word_r  <= '0;
      cur_bit_r   <= '0;
      cur_base_r  <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lim_r       <= lim_nxt;
      count_r     <= count_nxt;
      cur_word_r  <= cur_word_nxt;
      cur_bit_r   <= cur_bit_nxt;
      cur_base_r  <= cur_base_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_word_r  <= scan_word_nxt;
    scan_base_r  <= scan_base_nxt;
    lo_bit_r     <= lo_bit_nxt;
    idx_r        <= idx_nxt;
    rel_bit_r    <= rel_bit_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule
`default_nettype wire

FILE: src/nfba_bitmap_ram.sv
`default_nettype none
module nfba_bitmap_ram #(
  parameter int WORD_BITS = 64,
  parameter int DEPTH     = 16,
  parameter int AW        = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: src/nfba_ffz.sv
`default_nettype none
module nfba_ffz #(
  parameter int WORD_BITS = 64,
  parameter int BW        = 6,
  parameter int SW        = 12
) (
  input  logic [WORD_BITS-1:0] used_word,
  input  logic [BW-1:0]        lo_bit,   // first bit position to consider
  input  logic [SW-1:0]        span,     // ids left from the word base to the limit
  output logic                 found,
  output logic [BW-1:0]        hit_bit
);

  // lowest clear bit with lo_bit <= j < span
  always_comb begin
    found   = 1'b0;
    hit_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!used_word[j] && (BW'(j) >= lo_bit) && (SW'(j) < span)) begin
        found   = 1'b1;
        hit_bit = BW'(j);
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/nfba_wdiv.sv
`default_nettype none
module nfba_wdiv #(
  parameter int WORD_BITS = 64,
  parameter int IW        = 10,
  parameter int AW        = 4,
  parameter int BW        = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [IW-1:0] dividend,
  output logic          done,
  output logic [AW-1:0] quot,
  output logic [BW-1:0] rem_bits
);

  // index split into word address and bit position; WORD_BITS is a power of two,
  // so this is a plain shift and mask, ready in the cycle after start
  logic [IW-1:0] idx_r;
  logic          busy_r;

  assign done     = busy_r;
  assign quot     = AW'(idx_r / WORD_BITS);
  assign rem_bits = BW'(idx_r % WORD_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
    if (start) begin
      idx_r <= dividend;
    end
  end

endmodule
`default_nettype wire
